### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, removed when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked property, masked while reset is asserted
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// clocked property, checked through reset as well
`define ASSERT_CLK(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rstn, prop)
`define ASSERT_CLK(name, clk, prop)
`endif

`endif

### sv/nec_tx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nec_tx_pkg
// shared types and constants of the infrared frame transmitter
// ----------------------------------------------------------------------------
package nec_tx_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LEADER_MARK_END  = 3'd0;
  localparam logic [2:0] REG_LEADER_SPACE_END = 3'd1;
  localparam logic [2:0] REG_BIT_MARK_TICKS   = 3'd2;
  localparam logic [2:0] REG_ONE_SPACE_TICKS  = 3'd3;
  localparam logic [2:0] REG_ZERO_SPACE_TICKS = 3'd4;
  localparam logic [2:0] REG_FRAME_END_COUNT  = 3'd5;

  // reset values of the timing registers
  localparam logic [15:0] RST_LEADER_MARK_END  = 16'd900;
  localparam logic [15:0] RST_LEADER_SPACE_END = 16'd1350;
  localparam logic [7:0]  RST_BIT_MARK_TICKS   = 8'd56;
  localparam logic [7:0]  RST_ONE_SPACE_TICKS  = 8'd167;
  localparam logic [7:0]  RST_ZERO_SPACE_TICKS = 8'd55;
  localparam logic [15:0] RST_FRAME_END_COUNT  = 16'd11000;

  typedef enum logic [2:0] {
    FP_LEAD_START,
    FP_LEAD_MARK,
    FP_LEAD_SPACE,
    FP_DATA,
    FP_PAD
  } frame_phase_e;

  typedef enum logic [2:0] {
    BP_SELECT,
    BP_STOP,
    BP_MARK_START,
    BP_MARK,
    BP_SPACE_START,
    BP_SPACE
  } bit_phase_e;

  typedef struct packed {
    logic [15:0] leader_mark_end;
    logic [15:0] leader_space_end;
    logic [7:0]  bit_mark_ticks;
    logic [7:0]  one_space_ticks;
    logic [7:0]  zero_space_ticks;
    logic [15:0] frame_end_count;
  } cfg_t;

  typedef struct packed {
    logic frame_done;
    logic accepted;
    logic busy_res;
    logic carrier_on;
  } res_t;

endpackage
`default_nettype wire

### sv/nec_tx_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nec_tx_seq
// frame and bit sequencer: one tick or send request per step
// ----------------------------------------------------------------------------
module nec_tx_seq #(
  parameter int DATA_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             kind_i,
  input  wire logic [31:0]      frame_data_i,
  input  wire nec_tx_pkg::cfg_t cfg_i,
  output nec_tx_pkg::res_t      res_o
);
  import nec_tx_pkg::*;

  localparam int BI_W  = $clog2(DATA_BITS + 2);
  localparam int IDX_W = $clog2(DATA_BITS);
  localparam logic [BI_W-1:0] BI_LAST = BI_W'(DATA_BITS);
  localparam logic [BI_W-1:0] BI_STOP = BI_W'(DATA_BITS + 1);

  frame_phase_e         fp_q, fp_d;
  bit_phase_e           bp_q, bp_d;
  logic [15:0]          fc_q, fc_d;
  logic [7:0]           pc_q, pc_d;
  logic [BI_W-1:0]      bi_q, bi_d;
  logic                 cur_bit_q, cur_bit_d;
  logic [DATA_BITS-1:0] word_q, word_d;
  logic                 busy_q, busy_d;
  logic                 carrier_q, carrier_d;

  logic [63:0]          data_ext;
  logic [DATA_BITS-1:0] word_load;
  logic [7:0]           pc_plus;
  logic [7:0]           space_limit;
  logic                 took, done;

  // request word widened or cut to the frame length
  assign data_ext    = {32'b0, frame_data_i};
  assign word_load   = data_ext[DATA_BITS-1:0];
  assign pc_plus     = pc_q + 8'd1;
  assign space_limit = cur_bit_q ? cfg_i.one_space_ticks : cfg_i.zero_space_ticks;

  // next state
  always_comb begin
    fp_d      = fp_q;
    bp_d      = bp_q;
    fc_d      = fc_q;
    pc_d      = pc_q;
    bi_d      = bi_q;
    cur_bit_d = cur_bit_q;
    word_d    = word_q;
    busy_d    = busy_q;
    carrier_d = carrier_q;
    if (step_i) begin
      if (kind_i) begin
        if (!busy_q) begin
          busy_d = 1'b1;
          word_d = word_load;
        end
      end else if (busy_q) begin
        fc_d = fc_q + 16'd1;
        case (fp_q)
          FP_LEAD_START: begin
            carrier_d = 1'b1;
            fp_d      = FP_LEAD_MARK;
          end
          FP_LEAD_MARK: begin
            if (fc_q == cfg_i.leader_mark_end) begin
              carrier_d = 1'b0;
              fp_d      = FP_LEAD_SPACE;
            end else if (fc_q == cfg_i.leader_space_end) begin
              fp_d = FP_DATA;
            end
          end
          FP_LEAD_SPACE: begin
            if (fc_q == cfg_i.leader_space_end) begin
              fp_d = FP_DATA;
            end
          end
          FP_DATA: begin
            // bit sequencer
            case (bp_q)
              BP_SELECT: begin
                if (bi_q >= BI_LAST) begin
                  bp_d = BP_STOP;
                end else begin
                  cur_bit_d = word_q[bi_q[IDX_W-1:0]];
                  bi_d      = bi_q + BI_W'(1);
                  bp_d      = BP_MARK_START;
                end
              end
              BP_STOP: begin
                cur_bit_d = 1'b0;
                if (bi_q == BI_STOP) begin
                  bp_d = BP_SELECT;
                  pc_d = 8'd0;
                  bi_d = '0;
                  fp_d = FP_PAD;
                end else begin
                  bi_d = bi_q + BI_W'(1);
                  bp_d = BP_MARK_START;
                end
              end
              BP_MARK_START: begin
                carrier_d = 1'b1;
                if (pc_plus == cfg_i.bit_mark_ticks) begin
                  pc_d = 8'd0;
                  bp_d = BP_SPACE_START;
                end else begin
                  pc_d = pc_plus + 8'd1;
                  bp_d = BP_MARK;
                end
              end
              BP_MARK: begin
                if (pc_q == cfg_i.bit_mark_ticks) begin
                  pc_d = 8'd0;
                  bp_d = BP_SPACE_START;
                end else begin
                  pc_d = pc_plus;
                end
              end
              BP_SPACE_START: begin
                carrier_d = 1'b0;
                if (pc_plus == space_limit) begin
                  pc_d = 8'd0;
                  bp_d = BP_SELECT;
                end else begin
                  pc_d = pc_plus + 8'd1;
                  bp_d = BP_SPACE;
                end
              end
              BP_SPACE: begin
                if (pc_q == space_limit) begin
                  pc_d = 8'd0;
                  bp_d = BP_SELECT;
                end else begin
                  pc_d = pc_plus;
                end
              end
              default: begin
                bp_d = bp_q;
              end
            endcase
          end
          FP_PAD: begin
            carrier_d = 1'b0;
            if (fc_q == cfg_i.frame_end_count) begin
              fc_d   = 16'd0;
              fp_d   = FP_LEAD_START;
              busy_d = 1'b0;
            end
          end
          default: begin
            fp_d = fp_q;
          end
        endcase
      end
    end
  end

  // result of the step
  always_comb begin
    took = step_i && kind_i && !busy_q;
    done = step_i && !kind_i && busy_q && (fp_q == FP_PAD)
           && (fc_q == cfg_i.frame_end_count);
    res_o.carrier_on = carrier_d;
    res_o.busy_res   = busy_d;
    res_o.accepted   = took;
    res_o.frame_done = done;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q      <= FP_LEAD_START;
      bp_q      <= BP_SELECT;
      fc_q      <= 16'd0;
      pc_q      <= 8'd0;
      bi_q      <= '0;
      cur_bit_q <= 1'b0;
      busy_q    <= 1'b0;
      carrier_q <= 1'b0;
    end else begin
      fp_q      <= fp_d;
      bp_q      <= bp_d;
      fc_q      <= fc_d;
      pc_q      <= pc_d;
      bi_q      <= bi_d;
      cur_bit_q <= cur_bit_d;
      busy_q    <= busy_d;
      carrier_q <= carrier_d;
    end
  end

  // frame word, loaded on a taken request
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule
`default_nettype wire

### sv/nec_ir_frame_transmitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter
// infrared frame generator stepped in 10 us ticks, gating a carrier
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: kind, tdata: frame_data
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: carrier_on .. frame_done
// apb       in   psel, penable, pwrite, pready  six timing registers
//
// each request passes an input register, one step of the sequencer and a
// result register; one request accepted every cycle while m_axis_tready is high
// reset clears the sequencer, both stage valids and loads the default timing
// a stalled result register holds its request while the input register
// fills; s_axis_tready drops only when both stages are held
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter #(
  parameter int DATA_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] frame_data
  input  wire logic        s_axis_tuser,  // [0] kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] carrier_on, [1] busy_res,
                                          // [2] accepted, [3] frame_done
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import nec_tx_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic        in_valid_q;
  logic        in_kind_q;
  logic [31:0] in_data_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        advance;
  res_t        res;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_end  <= RST_LEADER_MARK_END;
      cfg_q.leader_space_end <= RST_LEADER_SPACE_END;
      cfg_q.bit_mark_ticks   <= RST_BIT_MARK_TICKS;
      cfg_q.one_space_ticks  <= RST_ONE_SPACE_TICKS;
      cfg_q.zero_space_ticks <= RST_ZERO_SPACE_TICKS;
      cfg_q.frame_end_count  <= RST_FRAME_END_COUNT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEADER_MARK_END:  cfg_q.leader_mark_end  <= pwdata[15:0];
        REG_LEADER_SPACE_END: cfg_q.leader_space_end <= pwdata[15:0];
        REG_BIT_MARK_TICKS:   cfg_q.bit_mark_ticks   <= pwdata[7:0];
        REG_ONE_SPACE_TICKS:  cfg_q.one_space_ticks  <= pwdata[7:0];
        REG_ZERO_SPACE_TICKS: cfg_q.zero_space_ticks <= pwdata[7:0];
        REG_FRAME_END_COUNT:  cfg_q.frame_end_count  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_LEADER_MARK_END:  prdata = {16'b0, cfg_q.leader_mark_end};
      REG_LEADER_SPACE_END: prdata = {16'b0, cfg_q.leader_space_end};
      REG_BIT_MARK_TICKS:   prdata = {24'b0, cfg_q.bit_mark_ticks};
      REG_ONE_SPACE_TICKS:  prdata = {24'b0, cfg_q.one_space_ticks};
      REG_ZERO_SPACE_TICKS: prdata = {24'b0, cfg_q.zero_space_ticks};
      REG_FRAME_END_COUNT:  prdata = {16'b0, cfg_q.frame_end_count};
      default:              prdata = 32'b0;
    endcase
  end

  // stage handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= {4'b0, res};
    end
  end

  // sequencer
  nec_tx_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .kind_i       (in_kind_q),
    .frame_data_i (in_data_q),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

`include "assert_macros.svh"

  // a taken request always leaves the block busy
  `ASSERT_RST(a_take_busy, clk_i, rst_ni, advance && res.accepted |-> res.busy_res)
  // the end of a frame leaves the emitter idle and the block free
  `ASSERT_RST(a_done_idle, clk_i, rst_ni,
              advance && res.frame_done |-> !res.busy_res && !res.carrier_on)
  // a stepped request always shows up in the result register
  `ASSERT_RST(a_step_out, clk_i, rst_ni, advance |=> out_valid_q)
  // input stage never drops a request while the result side stalls
  `ASSERT_CLK(a_hold_in, clk_i,
              rst_ni && in_valid_q && !advance |=> !rst_ni || in_valid_q)

endmodule
`default_nettype wire
